@@ sv/bfdh_pkg.sv @@
// shared types and constants of the double-hash bloom filter
`timescale 1ns / 1ps
package bfdh_pkg;

   localparam int HASH_W       = 64;
   localparam int WORD_W       = 64;
   localparam int BIT_SEL_W    = 6;
   localparam int BITS_W       = 17;
   localparam int PROBES_W     = 5;
   localparam int CSR_ADDR_W   = 2;
   localparam int CSR_DATA_W   = 17;
   localparam int REQ_DATA_W   = 2 * HASH_W;
   localparam int REQ_USER_W   = 2;
   localparam int RSP_DATA_W   = 8;
   localparam int DEF_MAX_BITS = 65536;
   localparam int MAX_PROBES   = 16;

   // remainder unit retires this many dividend bits per cycle
   localparam int STEP_BITS = 4;
   localparam int RED_STEPS = HASH_W / STEP_BITS;
   localparam int RED_CNT_W = $clog2(RED_STEPS);

   localparam logic [BITS_W-1:0]   BIT_COUNT_RST   = 17'h10000;
   localparam logic [PROBES_W-1:0] PROBE_COUNT_RST = 5'd7;

   typedef enum logic [REQ_USER_W-1:0] {
      OP_INSERT = 2'd0,
      OP_QUERY  = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_BIT_COUNT   = 2'd0,
      CSR_PROBE_COUNT = 2'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_REDUCE,
      ST_READ,
      ST_CHECK,
      ST_DONE
   } state_type;

endpackage

@@ sv/bfdh_mod.sv @@
// multi-cycle 64-bit remainder unit, a few dividend bits per cycle
`timescale 1ns / 1ps
module bfdh_mod (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [bfdh_pkg::HASH_W-1:0]   value,
   input  logic [bfdh_pkg::BITS_W-1:0]   modulus,
   output logic                          busy,
   output logic [bfdh_pkg::BITS_W-1:0]   remainder
);

   logic [bfdh_pkg::HASH_W-1:0]    val_ff, val_in;
   logic [bfdh_pkg::BITS_W-1:0]    rem_ff, rem_in;
   logic [bfdh_pkg::RED_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic [bfdh_pkg::BITS_W-1:0]    step_rem;
   logic [bfdh_pkg::BITS_W:0]      trial;

   // restoring remainder, msb first
   always_comb begin
      step_rem = rem_ff;
      trial    = '0;
      for (int s = 0; s < bfdh_pkg::STEP_BITS; s++) begin
         trial = {step_rem, val_ff[bfdh_pkg::HASH_W-1-s]};
         if (trial >= {1'b0, modulus}) begin
            trial = trial - {1'b0, modulus};
         end
         step_rem = trial[bfdh_pkg::BITS_W-1:0];
      end
   end

   always_comb begin
      val_in  = val_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         val_in  = value;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         val_in  = val_ff << bfdh_pkg::STEP_BITS;
         rem_in  = step_rem;
         cnt_in  = cnt_ff + 1'b1;
         busy_in = (cnt_ff != bfdh_pkg::RED_CNT_W'(bfdh_pkg::RED_STEPS - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      rem_ff <= rem_in;
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff;

endmodule

@@ sv/bloom_filter_double_hash.sv @@
// bloom filter with double hashing over a word-wide bit store memory
//
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  tdata: hash_a, hash_b; tuser: operation
//  rsp      out  rsp_tvalid/rsp_tready  tdata: present
//  csr      in   csr_we                 csr_addr, csr_wdata
//
// insert/query: accept, hash reduction, then a read and a check state per probe, then done;
//   each probe reads a store word and an insert writes it back with the bit set; a query stops at a clear bit
// clear: one word per cycle over the whole store, 1024 words by default
// after reset a clearing pass over the whole store runs before the first request is taken
// a waiting result does not stall the next request; a finished item holds in the
//   done state only while the output register is still full
`timescale 1ns / 1ps
module bloom_filter_double_hash #(
   parameter int MAX_BITS = bfdh_pkg::DEF_MAX_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [bfdh_pkg::REQ_DATA_W-1:0]   req_tdata,  // hash_a [63:0], hash_b [127:64]
   input  logic [bfdh_pkg::REQ_USER_W-1:0]   req_tuser,  // operation [1:0]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bfdh_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // present [0], zeros above
   input  logic                              csr_we,
   input  logic [bfdh_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [bfdh_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int WORDS = (MAX_BITS + bfdh_pkg::WORD_W - 1) / bfdh_pkg::WORD_W;
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam logic [31:0] MAX_BITS_V = 32'(MAX_BITS);
   localparam int RW    = bfdh_pkg::BITS_W + 2;

   bfdh_pkg::state_type state_ff, state_in;
   bfdh_pkg::op_type    op_ff, op_in, req_op;

   logic [bfdh_pkg::BITS_W-1:0]    bit_count_ff, bit_count_in;
   logic [bfdh_pkg::PROBES_W-1:0]  probe_count_ff, probe_count_in;
   logic [bfdh_pkg::BITS_W-1:0]    m_eff;
   logic [bfdh_pkg::PROBES_W-1:0]  k_eff;

   logic [bfdh_pkg::HASH_W-1:0]    hash_a, hash_b, b_eff;
   logic [bfdh_pkg::HASH_W-1:0]    x_ff, x_in, b_ff, b_in;
   logic [bfdh_pkg::HASH_W:0]      x_sum;
   logic [bfdh_pkg::BITS_W-1:0]    r_ff, r_in, r_next;
   logic [bfdh_pkg::BITS_W:0]      cw;
   logic [RW-1:0]                  r_sum;
   logic [bfdh_pkg::PROBES_W-1:0]  probe_ff, probe_in;
   logic [AW-1:0]                  addr_ff, addr_in;
   logic [bfdh_pkg::BIT_SEL_W-1:0] bit_ff, bit_in;
   logic                           present_ff, present_in;
   logic                           reply_ff, reply_in;
   logic [AW-1:0]                  clr_cnt_ff, clr_cnt_in;
   logic                           clr_last;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_data_ff, rsp_data_in;

   logic                           req_fire, out_free, hit;
   logic                           red_start, red_busy;
   logic                           busy_a, busy_b, busy_c;
   logic [bfdh_pkg::BITS_W-1:0]    rem_a, rem_b, rem_c;

   logic [bfdh_pkg::WORD_W-1:0]    store_mem [WORDS];
   logic [bfdh_pkg::WORD_W-1:0]    rd_data_ff;
   logic                           mem_rd, mem_we, rsp_load;
   logic [AW-1:0]                  rd_addr, wr_addr;
   logic [bfdh_pkg::WORD_W-1:0]    wr_data;

   assign hash_a   = req_tdata[bfdh_pkg::HASH_W-1:0];
   assign hash_b   = req_tdata[bfdh_pkg::REQ_DATA_W-1:bfdh_pkg::HASH_W];
   assign req_op   = bfdh_pkg::op_type'(req_tuser);
   assign b_eff    = (hash_b == '0) ? bfdh_pkg::HASH_W'(1) : hash_b;
   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign hit      = rd_data_ff[bit_ff];
   assign clr_last = (clr_cnt_ff == AW'(WORDS - 1));
   assign red_busy = busy_a || busy_b || busy_c;

   // effective modulus and probe count
   always_comb begin
      if (bit_count_ff == '0) begin
         m_eff = bfdh_pkg::BITS_W'(1);
      end else if (32'(bit_count_ff) > MAX_BITS_V) begin
         m_eff = bfdh_pkg::BITS_W'(MAX_BITS_V);
      end else begin
         m_eff = bit_count_ff;
      end
      if (32'(probe_count_ff) > 32'(bfdh_pkg::MAX_PROBES)) begin
         k_eff = bfdh_pkg::PROBES_W'(bfdh_pkg::MAX_PROBES);
      end else begin
         k_eff = probe_count_ff;
      end
   end

   // a mod m, b mod m and (2^64 - 1) mod m side by side
   bfdh_mod u_mod_a (
      .clock     (clock),
      .reset     (reset),
      .start     (red_start),
      .value     (hash_a),
      .modulus   (m_eff),
      .busy      (busy_a),
      .remainder (rem_a)
   );

   bfdh_mod u_mod_b (
      .clock     (clock),
      .reset     (reset),
      .start     (red_start),
      .value     (b_eff),
      .modulus   (m_eff),
      .busy      (busy_b),
      .remainder (rem_b)
   );

   bfdh_mod u_mod_c (
      .clock     (clock),
      .reset     (reset),
      .start     (red_start),
      .value     ({bfdh_pkg::HASH_W{1'b1}}),
      .modulus   (m_eff),
      .busy      (busy_c),
      .remainder (rem_c)
   );

   // next probe: add the stride residue, take off 2^64 mod m when the 64-bit sum wraps
   always_comb begin
      x_sum = {1'b0, x_ff} + {1'b0, b_ff};
      cw    = {1'b0, rem_c} + 1'b1;
      r_sum = RW'(r_ff) + RW'(rem_b);
      if (x_sum[bfdh_pkg::HASH_W]) begin
         r_sum = r_sum - RW'(cw);
      end
      if (r_sum[RW-1]) begin
         r_sum = r_sum + RW'(m_eff);
      end else if (r_sum >= RW'(m_eff)) begin
         r_sum = r_sum - RW'(m_eff);
      end
      r_next = r_sum[bfdh_pkg::BITS_W-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bfdh_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_op)
                  bfdh_pkg::OP_INSERT, bfdh_pkg::OP_QUERY: state_in = bfdh_pkg::ST_REDUCE;
                  bfdh_pkg::OP_CLEAR:                      state_in = bfdh_pkg::ST_CLEAR;
                  default:                                 state_in = bfdh_pkg::ST_DONE;
               endcase
            end
         end
         bfdh_pkg::ST_CLEAR: begin
            if (clr_last) begin
               state_in = reply_ff ? bfdh_pkg::ST_DONE : bfdh_pkg::ST_IDLE;
            end
         end
         bfdh_pkg::ST_REDUCE: begin
            if (!red_busy) begin
               state_in = (k_eff == '0) ? bfdh_pkg::ST_DONE : bfdh_pkg::ST_READ;
            end
         end
         bfdh_pkg::ST_READ: begin
            state_in = bfdh_pkg::ST_CHECK;
         end
         bfdh_pkg::ST_CHECK: begin
            if ((op_ff == bfdh_pkg::OP_QUERY && !hit) || probe_ff == k_eff) begin
               state_in = bfdh_pkg::ST_DONE;
            end else begin
               state_in = bfdh_pkg::ST_READ;
            end
         end
         bfdh_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = bfdh_pkg::ST_IDLE;
            end
         end
         default: state_in = bfdh_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_tready = 1'b0;
      red_start  = 1'b0;
      mem_rd     = 1'b0;
      mem_we     = 1'b0;
      rsp_load   = 1'b0;
      rd_addr    = AW'(r_ff >> bfdh_pkg::BIT_SEL_W);
      wr_addr    = addr_ff;
      wr_data    = rd_data_ff | (bfdh_pkg::WORD_W'(1) << bit_ff);
      case (state_ff)
         bfdh_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            red_start  = req_fire;
         end
         bfdh_pkg::ST_CLEAR: begin
            mem_we  = 1'b1;
            wr_addr = clr_cnt_ff;
            wr_data = '0;
         end
         bfdh_pkg::ST_READ: begin
            mem_rd = 1'b1;
         end
         bfdh_pkg::ST_CHECK: begin
            mem_we = (op_ff == bfdh_pkg::OP_INSERT);
         end
         bfdh_pkg::ST_DONE: begin
            rsp_load = out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      bit_count_in   = bit_count_ff;
      probe_count_in = probe_count_ff;
      op_in          = op_ff;
      x_in           = x_ff;
      b_in           = b_ff;
      r_in           = r_ff;
      probe_in       = probe_ff;
      addr_in        = addr_ff;
      bit_in         = bit_ff;
      present_in     = present_ff;
      reply_in       = reply_ff;
      clr_cnt_in     = clr_cnt_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;

      if (csr_we) begin
         case (bfdh_pkg::csr_index_type'(csr_addr))
            bfdh_pkg::CSR_BIT_COUNT:   bit_count_in = csr_wdata[bfdh_pkg::BITS_W-1:0];
            bfdh_pkg::CSR_PROBE_COUNT: probe_count_in = csr_wdata[bfdh_pkg::PROBES_W-1:0];
            default:                   bit_count_in = bit_count_ff;
         endcase
      end

      if (req_fire) begin
         op_in      = req_op;
         x_in       = hash_a;
         b_in       = b_eff;
         probe_in   = '0;
         present_in = (req_op == bfdh_pkg::OP_QUERY);
         reply_in   = 1'b1;
         clr_cnt_in = '0;
      end

      if (state_ff == bfdh_pkg::ST_CLEAR) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
      end
      if (state_ff == bfdh_pkg::ST_REDUCE && !red_busy) begin
         r_in = rem_a;
      end
      if (state_ff == bfdh_pkg::ST_READ) begin
         addr_in  = rd_addr;
         bit_in   = r_ff[bfdh_pkg::BIT_SEL_W-1:0];
         r_in     = r_next;
         x_in     = x_sum[bfdh_pkg::HASH_W-1:0];
         probe_in = probe_ff + 1'b1;
      end
      if (state_ff == bfdh_pkg::ST_CHECK && op_ff == bfdh_pkg::OP_QUERY && !hit) begin
         present_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_data_in  = present_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= bfdh_pkg::ST_CLEAR;
         clr_cnt_ff     <= '0;
         reply_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         bit_count_ff   <= bfdh_pkg::BIT_COUNT_RST;
         probe_count_ff <= bfdh_pkg::PROBE_COUNT_RST;
         probe_ff       <= '0;
      end else begin
         state_ff       <= state_in;
         clr_cnt_ff     <= clr_cnt_in;
         reply_ff       <= reply_in;
         rsp_valid_ff   <= rsp_valid_in;
         bit_count_ff   <= bit_count_in;
         probe_count_ff <= probe_count_in;
         probe_ff       <= probe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      x_ff        <= x_in;
      b_ff        <= b_in;
      r_ff        <= r_in;
      addr_ff     <= addr_in;
      bit_ff      <= bit_in;
      present_ff  <= present_in;
      rsp_data_ff <= rsp_data_in;
   end

   // bit store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (mem_rd) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = bfdh_pkg::RSP_DATA_W'(rsp_data_ff);

   a_one_item_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken twice in a row");

   a_insert_sets_bit: assert property (@(posedge clock) disable iff (reset)
      mem_we && state_ff == bfdh_pkg::ST_CHECK |-> wr_data[bit_ff])
      else $error("insert write-back lacks the probed bit");

   a_present_only_query: assert property (@(posedge clock) disable iff (reset)
      state_ff == bfdh_pkg::ST_DONE && op_ff != bfdh_pkg::OP_QUERY |-> !present_ff)
      else $error("present raised for a non-query word");

   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == bfdh_pkg::ST_READ |-> r_ff < m_eff)
      else $error("probe index not below bit count");

   a_probe_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == bfdh_pkg::ST_CHECK |-> probe_ff != '0 && probe_ff <= k_eff)
      else $error("probe counter out of range");

endmodule
